/* design/ivu_pkg.sv */
package ivu_pkg;

    // Component and result widths.
    localparam int CW         = 16;
    localparam int DW         = CW + 1;
    localparam int RW         = 32;
    localparam int SCW        = 35;
    localparam int LANES      = 4;

    // Square-root unit: one result bit per stage.
    localparam int RT_W       = 18;
    localparam int SQ_IN_W    = 2 * RT_W;
    localparam int SQ_STAGES  = RT_W;

    // Divider: one quotient bit per stage.
    localparam int DIV_STAGES = CW;

    // Command codes.
    localparam logic [3:0] CMD_ADD    = 4'd0;
    localparam logic [3:0] CMD_SUB    = 4'd1;
    localparam logic [3:0] CMD_SCALE  = 4'd2;
    localparam logic [3:0] CMD_DIV    = 4'd3;
    localparam logic [3:0] CMD_LENSQ  = 4'd4;
    localparam logic [3:0] CMD_LEN    = 4'd5;
    localparam logic [3:0] CMD_DIST   = 4'd6;
    localparam logic [3:0] CMD_DISTSQ = 4'd7;
    localparam logic [3:0] CMD_NORM   = 4'd8;
    localparam logic [3:0] CMD_EQ     = 4'd9;
    localparam logic [3:0] CMD_DOT    = 4'd10;
    localparam logic [3:0] CMD_CROSS  = 4'd11;

    // One result word.
    typedef struct packed {
        logic [LANES-1:0][RW-1:0] vec;
        logic [SCW-1:0]           sc;
        logic                     dz;
    } res_t;

    // What one lane found in the first stage.
    typedef struct packed {
        logic signed [RW-1:0] sum;
        logic signed [RW-1:0] diff;
        logic signed [RW-1:0] scl;
        logic signed [RW-1:0] dotp;
        logic signed [RW-1:0] crs;
        logic [RW-1:0]        sq;
        logic                 eq;
        logic [CW-1:0]        a;
    } lane_out_t;

    // Context carried beside the square-root and divide pipelines.
    typedef struct packed {
        logic [3:0]               cmd;
        res_t                     res;
        logic [LANES-1:0][CW-1:0] a;
        logic [CW-1:0]            s;
        logic [LANES-1:0]         neg;
        logic                     use_q;
    } ctx_t;

endpackage

/* design/ivu_lane.sv */
module ivu_lane import ivu_pkg::*; (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [3:0]           cmd,
    input  logic signed [CW-1:0] a,
    input  logic signed [CW-1:0] b,
    input  logic signed [CW-1:0] s,
    input  logic signed [CW-1:0] ca1,
    input  logic signed [CW-1:0] cb1,
    input  logic signed [CW-1:0] ca2,
    input  logic signed [CW-1:0] cb2,
    output lane_out_t            q
);

    logic signed [DW-1:0]   a_e;
    logic signed [DW-1:0]   b_e;
    logic signed [DW-1:0]   d;
    logic signed [DW-1:0]   sel;
    logic signed [2*DW-1:0] sq_full;
    logic signed [RW:0]     crs_full;
    lane_out_t              q_reg;
    lane_out_t              q_next;

    // Per-component sums, differences and products.
    always_comb begin
        a_e      = DW'(a);
        b_e      = DW'(b);
        d        = a_e - b_e;
        sel      = (cmd == CMD_DIST || cmd == CMD_DISTSQ) ? d : a_e;
        sq_full  = sel * sel;
        crs_full = (RW+1)'(ca1 * cb1) - (RW+1)'(ca2 * cb2);
        q_next.sum  = RW'(a_e + b_e);
        q_next.diff = RW'(d);
        q_next.scl  = RW'(a * s);
        q_next.dotp = RW'(a * b);
        q_next.crs  = crs_full[RW-1:0];
        q_next.sq   = sq_full[RW-1:0];
        q_next.eq   = (a == b);
        q_next.a    = a;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

/* design/ivu_isqrt.sv */
module ivu_isqrt import ivu_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic [SQ_IN_W-1:0] n,
    output logic [RT_W-1:0]    root
);

    logic [RT_W+1:0]   rem_reg  [SQ_STAGES];
    logic [RT_W+1:0]   rem_next [SQ_STAGES];
    logic [RT_W-1:0]   root_reg [SQ_STAGES];
    logic [RT_W-1:0]   root_next[SQ_STAGES];
    logic [SQ_IN_W-1:0] src_reg [SQ_STAGES];
    logic [SQ_IN_W-1:0] src_next[SQ_STAGES];

    // Each stage brings down two bits of the radicand and decides one root bit.
    always_comb begin
        logic [RT_W+1:0]    r_prev;
        logic [RT_W-1:0]    q_prev;
        logic [SQ_IN_W-1:0] s_prev;
        logic [RT_W+3:0]    r2;
        logic [RT_W+3:0]    trial;
        logic [RT_W+3:0]    r_sub;
        for (int k = 0; k < SQ_STAGES; k++) begin
            if (k == 0) begin
                r_prev = '0;
                q_prev = '0;
                s_prev = n;
            end else begin
                r_prev = rem_reg[k-1];
                q_prev = root_reg[k-1];
                s_prev = src_reg[k-1];
            end
            r2    = {r_prev, s_prev[SQ_IN_W-1 -: 2]};
            trial = {2'b00, q_prev, 2'b01};
            r_sub = r2 - trial;
            if (r2 >= trial) begin
                rem_next[k]  = r_sub[RT_W+1:0];
                root_next[k] = {q_prev[RT_W-2:0], 1'b1};
            end else begin
                rem_next[k]  = r2[RT_W+1:0];
                root_next[k] = {q_prev[RT_W-2:0], 1'b0};
            end
            src_next[k] = {s_prev[SQ_IN_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < SQ_STAGES; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                src_reg[k]  <= src_next[k];
            end
        end
    end

    assign root = root_reg[SQ_STAGES-1];

endmodule

/* design/ivu_div.sv */
module ivu_div import ivu_pkg::*; (
    input  logic          aclk,
    input  logic          en,
    input  logic [CW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [CW-1:0] quo
);

    logic [DW-1:0] rem_reg [DIV_STAGES];
    logic [DW-1:0] rem_next[DIV_STAGES];
    logic [CW-1:0] q_reg   [DIV_STAGES];
    logic [CW-1:0] q_next  [DIV_STAGES];
    logic [CW-1:0] n_reg   [DIV_STAGES];
    logic [CW-1:0] n_next  [DIV_STAGES];
    logic [DW-1:0] d_reg   [DIV_STAGES];
    logic [DW-1:0] d_next  [DIV_STAGES];

    // Restoring division of magnitudes, one quotient bit per stage.
    always_comb begin
        logic [DW-1:0] r_prev;
        logic [CW-1:0] q_prev;
        logic [CW-1:0] n_prev;
        logic [DW-1:0] d_prev;
        logic [DW:0]   r2;
        logic [DW:0]   r_sub;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                r_prev = '0;
                q_prev = '0;
                n_prev = num;
                d_prev = den;
            end else begin
                r_prev = rem_reg[k-1];
                q_prev = q_reg[k-1];
                n_prev = n_reg[k-1];
                d_prev = d_reg[k-1];
            end
            r2    = {r_prev, n_prev[CW-1]};
            r_sub = r2 - {1'b0, d_prev};
            if (r2 >= {1'b0, d_prev}) begin
                rem_next[k] = r_sub[DW-1:0];
                q_next[k]   = {q_prev[CW-2:0], 1'b1};
            end else begin
                rem_next[k] = r2[DW-1:0];
                q_next[k]   = {q_prev[CW-2:0], 1'b0};
            end
            n_next[k] = {n_prev[CW-2:0], 1'b0};
            d_next[k] = d_prev;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                rem_reg[k] <= rem_next[k];
                q_reg[k]   <= q_next[k];
                n_reg[k]   <= n_next[k];
                d_reg[k]   <= d_next[k];
            end
        end
    end

    assign quo = q_reg[DIV_STAGES-1];

endmodule

/* design/integer_vector_unit.sv */
// Four-component signed integer vector unit. Each input word carries two
// vectors, a scalar and a command (add, subtract, scale, divide by scalar,
// length squared, length, distance, distance squared, normalize, equality,
// dot, cross) and produces one result word: a 32-bit vector, a 35-bit scalar
// and a divide-by-zero flag. The unit is fully pipelined and takes one word
// every cycle; its stages are one lane stage, one merge stage, 18
// square-root stages (one root bit each), 16 divide stages (one quotient bit
// each) and the output register. Every command passes the whole pipeline, so
// results leave in input order. A stall on the output side holds the whole
// pipeline.
module integer_vector_unit import ivu_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, scalar_in (16 bits each)
    input  logic [143:0] s_axis_tdata,
    // command
    input  logic [3:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_x, res_y, res_z, res_w (32 bits each), res_scalar (35 bits), zero pad
    output logic [167:0] m_axis_tdata,
    // div_zero
    output logic [0:0]   m_axis_tuser
);

    logic                 adv;
    logic signed [CW-1:0] a_in [LANES];
    logic signed [CW-1:0] b_in [LANES];
    logic signed [CW-1:0] s_in;
    lane_out_t            lo   [LANES];

    logic                 v1_reg;
    logic [3:0]           cmd1_reg;
    logic [CW-1:0]        s1_reg;

    logic                 v2_reg;
    ctx_t                 ctx2_reg;
    ctx_t                 ctx2_next;
    logic [SCW-1:0]       n2_reg;
    logic [SCW-1:0]       sumsq;
    logic [SCW-1:0]       dot;

    logic                 vsq_reg  [SQ_STAGES];
    ctx_t                 ctx_sq_reg[SQ_STAGES];
    logic [RT_W-1:0]      root;

    ctx_t                 cd;
    logic                 s_neg;
    logic [DW-1:0]        s_ext;
    logic [DW-1:0]        s_mag;
    logic [DW-1:0]        den;
    logic [DW-1:0]        a_mag [LANES];

    logic                 vdv_reg  [DIV_STAGES];
    ctx_t                 ctx_dv_reg[DIV_STAGES];
    logic [CW-1:0]        quo  [LANES];

    res_t                 fin;
    res_t                 out_reg;
    logic [3:0]           out_cmd_reg;
    logic                 m_valid_reg;

    // The pipeline moves whenever the output register is free or being taken.
    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // Unpack the input word and run the per-component lanes.
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;
        assign a_in[i] = s_axis_tdata[i*CW +: CW];
        assign b_in[i] = s_axis_tdata[(LANES+i)*CW +: CW];
        if (i < 3) begin : g_crs
            ivu_lane u_lane (
                .aclk(aclk), .en(adv), .cmd(s_axis_tuser),
                .a(a_in[i]), .b(b_in[i]), .s(s_in),
                .ca1(s_axis_tdata[J*CW +: CW]), .cb1(s_axis_tdata[(LANES+K)*CW +: CW]),
                .ca2(s_axis_tdata[K*CW +: CW]), .cb2(s_axis_tdata[(LANES+J)*CW +: CW]),
                .q(lo[i])
            );
        end else begin : g_nocrs
            ivu_lane u_lane (
                .aclk(aclk), .en(adv), .cmd(s_axis_tuser),
                .a(a_in[i]), .b(b_in[i]), .s(s_in),
                .ca1('0), .cb1('0), .ca2('0), .cb2('0),
                .q(lo[i])
            );
        end
    end
    assign s_in = s_axis_tdata[2*LANES*CW +: CW];

    // Merge the lanes: sums over components and the results that need no
    // root or quotient.
    always_comb begin
        sumsq = '0;
        dot   = '0;
        for (int i = 0; i < LANES; i++) begin
            sumsq = sumsq + {{(SCW-RW){1'b0}}, lo[i].sq};
            dot   = dot + SCW'(lo[i].dotp);
        end
        ctx2_next     = '0;
        ctx2_next.cmd = cmd1_reg;
        ctx2_next.s   = s1_reg;
        for (int i = 0; i < LANES; i++) begin
            ctx2_next.a[i] = lo[i].a;
        end
        case (cmd1_reg)
            CMD_ADD: begin
                for (int i = 0; i < LANES; i++) ctx2_next.res.vec[i] = lo[i].sum;
            end
            CMD_SUB: begin
                for (int i = 0; i < LANES; i++) ctx2_next.res.vec[i] = lo[i].diff;
            end
            CMD_SCALE: begin
                for (int i = 0; i < LANES; i++) ctx2_next.res.vec[i] = lo[i].scl;
            end
            CMD_LENSQ, CMD_DISTSQ: ctx2_next.res.sc = sumsq;
            CMD_EQ: ctx2_next.res.sc = SCW'(lo[0].eq && lo[1].eq && lo[2].eq && lo[3].eq);
            CMD_DOT: ctx2_next.res.sc = dot;
            CMD_CROSS: begin
                for (int i = 0; i < 3; i++) ctx2_next.res.vec[i] = lo[i].crs;
            end
            default: ;
        endcase
    end

    ivu_isqrt u_isqrt (
        .aclk(aclk), .en(adv), .n({{(SQ_IN_W-SCW){1'b0}}, n2_reg}), .root(root)
    );

    // Root available: fill in length and distance, flag divide by zero, set up the dividers.
    always_comb begin
        cd    = ctx_sq_reg[SQ_STAGES-1];
        s_neg = cd.s[CW-1];
        s_ext = {cd.s[CW-1], cd.s};
        s_mag = s_neg ? (DW'(0) - s_ext) : s_ext;
        den   = (cd.cmd == CMD_NORM) ? root[DW-1:0] : s_mag;
        if (cd.cmd == CMD_LEN || cd.cmd == CMD_DIST) begin
            cd.res.sc = {{(SCW-RT_W){1'b0}}, root};
        end
        if (cd.cmd == CMD_DIV && cd.s == '0) begin
            cd.res.dz = 1'b1;
        end
        cd.use_q = (cd.cmd == CMD_DIV && cd.s != '0) ||
                   (cd.cmd == CMD_NORM && root != '0);
        for (int i = 0; i < LANES; i++) begin
            a_mag[i]  = cd.a[i][CW-1] ? (DW'(0) - {cd.a[i][CW-1], cd.a[i]})
                                       : {cd.a[i][CW-1], cd.a[i]};
            cd.neg[i] = cd.a[i][CW-1] ^ (cd.cmd == CMD_DIV && s_neg);
        end
    end

    for (genvar i = 0; i < LANES; i++) begin : g_div
        ivu_div u_div (
            .aclk(aclk), .en(adv), .num(a_mag[i][CW-1:0]), .den(den), .quo(quo[i])
        );
    end

    // Apply the quotient signs for divide and normalize.
    always_comb begin
        logic [RW-1:0] qe;
        fin = ctx_dv_reg[DIV_STAGES-1].res;
        for (int i = 0; i < LANES; i++) begin
            qe = {{(RW-CW){1'b0}}, quo[i]};
            if (ctx_dv_reg[DIV_STAGES-1].use_q) begin
                fin.vec[i] = ctx_dv_reg[DIV_STAGES-1].neg[i] ? (RW'(0) - qe) : qe;
            end
        end
    end

    // Valid bits of every stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < SQ_STAGES; k++) vsq_reg[k] <= 1'b0;
            for (int k = 0; k < DIV_STAGES; k++) vdv_reg[k] <= 1'b0;
        end else if (adv) begin
            v1_reg      <= s_axis_tvalid;
            v2_reg      <= v1_reg;
            vsq_reg[0]  <= v2_reg;
            for (int k = 1; k < SQ_STAGES; k++) vsq_reg[k] <= vsq_reg[k-1];
            vdv_reg[0]  <= vsq_reg[SQ_STAGES-1];
            for (int k = 1; k < DIV_STAGES; k++) vdv_reg[k] <= vdv_reg[k-1];
            m_valid_reg <= vdv_reg[DIV_STAGES-1];
        end
    end

    // Payload registers of the stages.
    always_ff @(posedge aclk) begin
        if (adv) begin
            cmd1_reg      <= s_axis_tuser;
            s1_reg        <= s_in;
            ctx2_reg      <= ctx2_next;
            n2_reg        <= sumsq;
            ctx_sq_reg[0] <= ctx2_reg;
            for (int k = 1; k < SQ_STAGES; k++) ctx_sq_reg[k] <= ctx_sq_reg[k-1];
            ctx_dv_reg[0] <= cd;
            for (int k = 1; k < DIV_STAGES; k++) ctx_dv_reg[k] <= ctx_dv_reg[k-1];
            out_reg       <= fin;
            out_cmd_reg   <= ctx_dv_reg[DIV_STAGES-1].cmd;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, out_reg.sc, out_reg.vec};
    assign m_axis_tuser  = out_reg.dz;

`ifndef ASSERT_OFF
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("output word valid right after reset");

    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && out_reg.dz |-> out_reg.vec == '0 && out_reg.sc == '0 &&
        out_cmd_reg == CMD_DIV)
        else $error("divide-by-zero word carries data or wrong command");

    a_eq_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && out_cmd_reg == CMD_EQ |-> out_reg.vec == '0 &&
        out_reg.sc[SCW-1:1] == '0 && !out_reg.dz)
        else $error("equality word is not a plain flag");
`endif

endmodule

/* dv/integer_vector_unit_test.sv */
module integer_vector_unit_test;
    import ivu_pkg::*;

    // One vector word as it enters the unit.
    typedef struct {
        logic [3:0]        cmd;
        logic signed [15:0] a [4];
        logic signed [15:0] b [4];
        logic signed [15:0] s;
    } vec_word_t;

    // One result word as it leaves the unit.
    typedef struct {
        logic [31:0] v [4];
        logic [34:0] sc;
        logic        dz;
    } vec_result_t;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic [3:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [167:0] m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    int  mismatches;
    bit  calm;
    bit  hold_long;

    // Report one mismatch and count it.
    task automatic report(input string what);
        $display("MISMATCH %s at %0t", what, $realtime);
        mismatches++;
    endtask

    // Floor square root of a 64-bit value.
    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return r;
    endfunction

    // Sum of squares of four components.
    function automatic longint unsigned square_sum(input longint c [4]);
        longint unsigned t;
        t = 0;
        for (int i = 0; i < 4; i++) t += c[i] * c[i];
        return t;
    endfunction

    // Compute the result word the unit should return for one input word.
    function automatic vec_result_t vector_op(input vec_word_t w);
        vec_result_t r;
        longint a [4];
        longint b [4];
        longint d [4];
        longint vec [4];
        longint s;
        longint len;
        longint unsigned sc;
        s = w.s;
        sc = 0;
        r.dz = 1'b0;
        for (int i = 0; i < 4; i++) begin
            a[i] = w.a[i];
            b[i] = w.b[i];
            d[i] = a[i] - b[i];
            vec[i] = 0;
        end
        case (w.cmd)
            CMD_ADD:    for (int i = 0; i < 4; i++) vec[i] = a[i] + b[i];
            CMD_SUB:    for (int i = 0; i < 4; i++) vec[i] = d[i];
            CMD_SCALE:  for (int i = 0; i < 4; i++) vec[i] = a[i] * s;
            CMD_DIV: begin
                if (s == 0) r.dz = 1'b1;
                else for (int i = 0; i < 4; i++) vec[i] = a[i] / s;
            end
            CMD_LENSQ:  sc = square_sum(a);
            CMD_LEN:    sc = floor_root(square_sum(a));
            CMD_DIST:   sc = floor_root(square_sum(d));
            CMD_DISTSQ: sc = square_sum(d);
            CMD_NORM: begin
                len = floor_root(square_sum(a));
                if (len != 0) for (int i = 0; i < 4; i++) vec[i] = a[i] / len;
            end
            CMD_EQ:     sc = (a == b) ? 1 : 0;
            CMD_DOT:    for (int i = 0; i < 4; i++) sc += a[i] * b[i];
            CMD_CROSS: begin
                vec[0] = a[1] * b[2] - a[2] * b[1];
                vec[1] = a[2] * b[0] - a[0] * b[2];
                vec[2] = a[0] * b[1] - a[1] * b[0];
            end
            default: ;
        endcase
        for (int i = 0; i < 4; i++) r.v[i] = vec[i][31:0];
        r.sc = sc[34:0];
        return r;
    endfunction

    // Scoreboard: expected result words in input order.
    class vector_scoreboard;
        vec_result_t pending_results [$];

        function void note_word(vec_word_t w);
            pending_results.push_back(vector_op(w));
        endfunction

        task check_result(logic [167:0] data, logic dz);
            vec_result_t e;
            if (pending_results.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            e = pending_results.pop_front();
            for (int i = 0; i < 4; i++)
                if (data[32*i +: 32] !== e.v[i])
                    report($sformatf("lane %0d got %h want %h", i, data[32*i +: 32], e.v[i]));
            if (data[162:128] !== e.sc)
                report($sformatf("scalar got %h want %h", data[162:128], e.sc));
            if (data[167:163] !== 5'd0) report("pad bits not zero");
            if (dz !== e.dz) report($sformatf("div_zero got %b want %b", dz, e.dz));
        endtask
    endclass

    vector_scoreboard board;

    integer_vector_unit uut (.*);

    // Clock.
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Send one word and wait for its handshake, with optional idle burst before.
    // The valid stays up afterwards so that words can follow back to back.
    task automatic send_word(input vec_word_t w);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.cmd;
        s_axis_tdata  <= {w.s, w.b[3], w.b[2], w.b[1], w.b[0], w.a[3], w.a[2], w.a[1], w.a[0]};
        do @(posedge aclk); while (!s_axis_tready);
        board.note_word(w);
        @(negedge aclk);
    endtask

    // Stop offering words and wait until every expected result has come.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic signed [15:0] rand_comp(input int mode);
        case (mode)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 7) - 3);
            3: return 16'($urandom_range(0, 400) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic vec_word_t rand_word();
        vec_word_t w;
        int mode;
        mode = $urandom_range(0, 6);
        w.cmd = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15))
                                             : 4'($urandom_range(0, 11));
        for (int i = 0; i < 4; i++) begin
            w.a[i] = rand_comp((mode > 4) ? $urandom_range(0, 4) : mode);
            w.b[i] = ($urandom_range(0, 5) == 0) ? w.a[i] : rand_comp($urandom_range(0, 4));
        end
        // Zero divisor and zero vector now and then.
        w.s = ($urandom_range(0, 7) == 0) ? 16'sd0 : rand_comp($urandom_range(0, 4));
        if ($urandom_range(0, 15) == 0) for (int i = 0; i < 4; i++) w.a[i] = '0;
        return w;
    endfunction

    function automatic vec_word_t fill_word(input logic [3:0] cmd, input logic signed [15:0] av,
                                            input logic signed [15:0] bv,
                                            input logic signed [15:0] sv);
        vec_word_t w;
        w.cmd = cmd;
        for (int i = 0; i < 4; i++) begin
            w.a[i] = av;
            w.b[i] = bv;
        end
        w.s = sv;
        return w;
    endfunction

    // Receiver: random stalls, one long hold-off on request, none when calm.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else if (hold_long) begin
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Sample results.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    // Long receiver hold-off, counted in its own process.
    initial begin
        hold_long = 1'b0;
        wait (aresetn);
        repeat (300) @(negedge aclk);
        hold_long = 1'b1;
        repeat (200) @(negedge aclk);
        hold_long = 1'b0;
    end

    // Stimulus.
    initial begin
        logic [3:0] c;
        vec_word_t w;
        board = new();
        mismatches = 0;
        calm = 1'b0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: every command at the extremes, divide by zero, zero-length normalize.
        for (int k = 0; k < 12; k++) begin
            c = 4'(k);
            send_word(fill_word(c, 16'sh8000, 16'sh7fff, 16'sh8000));
        end
        send_word(fill_word(CMD_DIV, 16'sh7fff, 16'sh0000, 16'sd0));
        send_word(fill_word(CMD_DIV, 16'sh8000, 16'sh0000, -16'sd1));
        send_word(fill_word(CMD_NORM, 16'sd0, 16'sd0, 16'sd0));
        send_word(fill_word(CMD_NORM, -16'sd7, 16'sd0, 16'sd0));
        send_word(fill_word(CMD_EQ, 16'sh8000, 16'sh8000, 16'sd0));
        send_word(fill_word(CMD_LENSQ, 16'sh8000, 16'sd0, 16'sd0));
        send_word(fill_word(CMD_DOT, 16'sh8000, 16'sh8000, 16'sd0));
        send_word(fill_word(CMD_SCALE, 16'sh8000, 16'sd0, 16'sh7fff));
        send_word(fill_word(4'd15, 16'sh7fff, 16'sh7fff, 16'sh7fff));
        w = fill_word(CMD_CROSS, 16'sd3, 16'sd0, 16'sd0);
        w.a[1] = -16'sd5; w.b[0] = 16'sh7fff; w.b[2] = 16'sh8000;
        send_word(w);

        // Random words; pause once until the pipe is empty.
        for (int n = 0; n < 1300; n++) begin
            if (n == 600) drain();
            if (n == 1100) calm = 1'b1;
            send_word(rand_word());
        end

        drain();
        repeat (50) @(posedge aclk);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Timeout.
    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
